// File: sv/uer_pkg.sv
`default_nettype none

package uer_pkg;

  // Width of the per-phase tick counter
  localparam int COUNTER_BITS = 16;
  localparam int CNT_MAX      = (1 << COUNTER_BITS) - 1;

  // Configuration register indexes
  localparam logic [1:0] REG_TIMEOUT  = 2'd0;
  localparam logic [1:0] REG_MM_Q16   = 2'd1;
  localparam logic [1:0] REG_MAX_DIST = 2'd2;
  localparam logic [1:0] REG_TRIGGER  = 2'd3;

  // Measurement status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_NO_ECHO  = 2'd1;
  localparam logic [1:0] ST_TOO_LONG = 2'd2;
  localparam logic [1:0] ST_BEYOND   = 2'd3;

  typedef struct packed {
    logic start_request;
    logic echo_level;
  } in_t;

  typedef struct packed {
    logic        trigger_level;
    logic        busy_res;
    logic        done_res;
    logic [15:0] range_mm;
    logic [1:0]  status;
  } out_t;

  typedef struct packed {
    logic [15:0] timeout_ticks;
    logic [15:0] mm_per_tick_q16;
    logic [15:0] max_distance_mm;
    logic [7:0]  trigger_ticks;
  } cfg_t;

endpackage

`default_nettype wire

// File: sv/ultrasonic_echo_ranger.sv
// Channel | Signals                            | Transaction
// --------+------------------------------------+------------------------------------
// in      | in_valid, in_ready, in_data        | one tick: start_request, echo_level
// out     | out_valid, out_ready, out_data     | one result per tick item
// cfg     | cfg_valid, cfg_ready, cfg_index,   | register write, always ready
//         | cfg_data                           |
//
// One item per cycle sustained while the output is not stalled; each result passes through
// the input register and then the result register around the step logic.
// The step logic does one 16x16 multiply and a compare at echo fall.
// Reset (rst, synchronous) clears the ranging state and loads default register values.
// A stalled output holds its result; the input register takes one more item and then
// in_ready drops until the result is taken.
`default_nettype none

module ultrasonic_echo_ranger (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          in_valid,
  output      logic          in_ready,
  input  wire uer_pkg::in_t  in_data,
  output      logic          out_valid,
  input  wire logic          out_ready,
  output      uer_pkg::out_t out_data,
  input  wire logic          cfg_valid,
  output      logic          cfg_ready,
  input  wire logic [1:0]    cfg_index,
  input  wire logic [15:0]   cfg_data
);

  logic          s1_valid;
  uer_pkg::in_t  s1_data;
  logic          s1_adv;
  uer_pkg::cfg_t cfg;
  uer_pkg::out_t res;

  assign s1_adv    = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || s1_adv;
  assign cfg_ready = 1'b1;

  uer_fsm u_fsm (
    .clk  (clk),
    .rst  (rst),
    .step (s1_adv),
    .item (s1_data),
    .cfg  (cfg),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid            <= 1'b0;
      out_valid           <= 1'b0;
      cfg.timeout_ticks   <= 16'd25000;
      cfg.mm_per_tick_q16 <= 16'd11239;
      cfg.max_distance_mm <= 16'd4000;
      cfg.trigger_ticks   <= 8'd10;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cfg_valid) begin
        case (cfg_index)
          uer_pkg::REG_TIMEOUT:  cfg.timeout_ticks   <= cfg_data;
          uer_pkg::REG_MM_Q16:   cfg.mm_per_tick_q16 <= cfg_data;
          uer_pkg::REG_MAX_DIST: cfg.max_distance_mm <= cfg_data;
          uer_pkg::REG_TRIGGER:  cfg.trigger_ticks   <= cfg_data[7:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: load on transfer, no reset
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_data <= in_data;
    end
    if (s1_adv) begin
      out_data <= res;
    end
  end

endmodule

`default_nettype wire

// File: sv/uer_fsm.sv
`default_nettype none

module uer_fsm (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          step,
  input  wire uer_pkg::in_t  item,
  input  wire uer_pkg::cfg_t cfg,
  output uer_pkg::out_t      res
);

  localparam int CW = uer_pkg::COUNTER_BITS;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_TRIG,
    PH_RISE,
    PH_FALL
  } phase_t;

  phase_t          phase, phase_next;
  logic [CW-1:0]   tick_counter, tick_counter_next;
  logic [15:0]     last_distance, last_distance_next;
  logic [1:0]      last_status, last_status_next;

  logic [31:0]     lim;
  logic [31:0]     tlen;
  logic [CW-1:0]   cnt_inc;
  logic [CW+15:0]  prod;
  logic [31:0]     prod_hi;
  logic [15:0]     range_calc;
  logic            trig;
  logic            done;

  // Budget saturates at the counter's largest value
  assign lim  = (32'(cfg.timeout_ticks) > 32'(uer_pkg::CNT_MAX)) ?
                32'(uer_pkg::CNT_MAX) : 32'(cfg.timeout_ticks);
  assign tlen = (cfg.trigger_ticks == 8'd0) ? 32'd1 : 32'(cfg.trigger_ticks);

  assign prod       = (CW+16)'(tick_counter) * (CW+16)'(cfg.mm_per_tick_q16);
  assign prod_hi    = 32'(prod[CW+15:16]);
  assign range_calc = (prod_hi > 32'h0000_FFFF) ? 16'hFFFF : prod_hi[15:0];

  always_comb begin
    phase_next         = phase;
    tick_counter_next  = tick_counter;
    last_distance_next = last_distance;
    last_status_next   = last_status;
    trig               = 1'b0;
    done               = 1'b0;
    cnt_inc            = tick_counter + CW'(1);

    // A start while idle enters the trigger phase on this same tick
    if (phase == PH_IDLE && item.start_request) begin
      phase_next        = PH_TRIG;
      tick_counter_next = '0;
      cnt_inc           = CW'(1);
    end

    case (phase_next)
      PH_TRIG: begin
        trig              = 1'b1;
        tick_counter_next = cnt_inc;
        if (32'(cnt_inc) >= tlen) begin
          phase_next        = PH_RISE;
          tick_counter_next = '0;
        end
      end
      PH_RISE: begin
        if (32'(tick_counter) >= lim || (!item.echo_level && 32'(cnt_inc) >= lim)) begin
          last_status_next  = uer_pkg::ST_NO_ECHO;
          phase_next        = PH_IDLE;
          tick_counter_next = '0;
          done              = 1'b1;
        end else if (item.echo_level) begin
          phase_next        = PH_FALL;
          tick_counter_next = '0;
        end else begin
          tick_counter_next = cnt_inc;
        end
      end
      PH_FALL: begin
        if (32'(tick_counter) >= lim || (item.echo_level && 32'(cnt_inc) >= lim)) begin
          last_status_next  = uer_pkg::ST_TOO_LONG;
          phase_next        = PH_IDLE;
          tick_counter_next = '0;
          done              = 1'b1;
        end else if (!item.echo_level) begin
          last_distance_next = range_calc;
          last_status_next   = (range_calc <= cfg.max_distance_mm) ?
                               uer_pkg::ST_OK : uer_pkg::ST_BEYOND;
          phase_next         = PH_IDLE;
          tick_counter_next  = '0;
          done               = 1'b1;
        end else begin
          tick_counter_next = cnt_inc;
        end
      end
      default: begin
      end
    endcase

    res.trigger_level = trig;
    res.busy_res      = (phase_next != PH_IDLE);
    res.done_res      = done;
    res.range_mm      = last_distance_next;
    res.status        = last_status_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase         <= PH_IDLE;
      tick_counter  <= '0;
      last_distance <= '0;
      last_status   <= '0;
    end else if (step) begin
      phase         <= phase_next;
      tick_counter  <= tick_counter_next;
      last_distance <= last_distance_next;
      last_status   <= last_status_next;
    end
  end

  a_done_not_busy: assert property (@(posedge clk) disable iff (rst)
    res.done_res |-> !res.busy_res)
    else $error("done result while still busy");

  a_trig_busy: assert property (@(posedge clk) disable iff (rst)
    res.trigger_level |-> res.busy_res)
    else $error("trigger driven outside a measurement");

  a_fail_keeps_dist: assert property (@(posedge clk) disable iff (rst)
    res.done_res && (res.status == uer_pkg::ST_NO_ECHO || res.status == uer_pkg::ST_TOO_LONG)
    |-> res.range_mm == last_distance)
    else $error("failed measurement changed distance");

  a_idle_holds: assert property (@(posedge clk) disable iff (rst)
    step && phase == PH_IDLE && !item.start_request |=> phase == PH_IDLE)
    else $error("left idle without a start");

endmodule

`default_nettype wire
